@@ src/span_region_clip_intersect_macros.svh @@
// Assertion macros shared by the span region clipper modules.
`ifndef SPAN_REGION_CLIP_INTERSECT_MACROS_SVH
`define SPAN_REGION_CLIP_INTERSECT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define SRCI_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define SRCI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/srci_pkg.sv @@
// Types, constants and helper functions of the span region clipper.
package srci_pkg;

    localparam int CLIP_DEPTH_DEF = 1024;
    localparam int COUNT_W        = 11;
    localparam int MAX_PIECES     = 64;
    localparam int PCNT_W         = 7;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;
    localparam int END_W          = 18;

    localparam logic [15:0] ROUND_BIAS = 16'h0080;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SPAN = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [9:0]        entry_index;
        logic signed [15:0] span_x;
        logic signed [15:0] span_y;
        logic [15:0]       span_len;
        logic [7:0]        span_coverage;
        logic              last_of_draw;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]       out_len;
        logic [7:0]        out_coverage;
        logic              last_piece;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]       len;
        logic [7:0]        cov;
    } clip_entry_t;

    localparam int ENTRY_W = $bits(clip_entry_t);

    typedef struct packed {
        logic                    is_load;
        logic                    load_ok;
        logic [9:0]              entry_index;
        logic signed [15:0]      span_x;
        logic signed [15:0]      span_y;
        logic [15:0]             span_len;
        logic [7:0]              span_coverage;
        logic                    last_of_draw;
        logic signed [END_W-1:0] span_end;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

    // Divides a product of two coverages by 255 with rounding.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] sum;
        begin
            sum = p + (p >> 8) + ROUND_BIAS;
            return sum[15:8];
        end
    endfunction

endpackage

@@ src/srci_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module srci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/srci_front.sv @@
// Front part: accepts items, classifies them and queues them for the back part.
`include "span_region_clip_intersect_macros.svh"

module srci_front #(
    parameter int CLIP_DEPTH = srci_pkg::CLIP_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  span_valid,
    output logic                  span_ready,
    input  srci_pkg::in_item_t    span,
    output srci_pkg::queue_head_t q_head,
    input  logic                  q_pop
);

    import srci_pkg::*;

    queue_item_t       fifo_reg [QUEUE_DEPTH];
    queue_item_t       entry;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    always_comb
    begin
        entry.is_load       = (span.opcode == OP_LOAD);
        entry.load_ok       = (32'(span.entry_index) < 32'(CLIP_DEPTH));
        entry.entry_index   = span.entry_index;
        entry.span_x        = span.span_x;
        entry.span_y        = span.span_y;
        entry.span_len      = span.span_len;
        entry.span_coverage = span.span_coverage;
        entry.last_of_draw  = span.last_of_draw;
        entry.span_end      = END_W'(span.span_x) + $signed({2'b00, span.span_len});
    end

    assign span_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push         = span_valid && span_ready;
    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

    `SRCI_ASSERT(a_count_bound, (count_reg <= QCNT_W'(QUEUE_DEPTH)), "queue count overflow")
    `SRCI_ASSERT_IMPL(a_pop_nonempty, q_pop, (count_reg != '0), "pop from empty queue")
    `SRCI_ASSERT_IMPL(a_empty_ptrs, (count_reg == '0), (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree")

endmodule

@@ src/srci_back.sv @@
// Back part: walks the clip table for each span and delivers the clipped pieces.
`include "span_region_clip_intersect_macros.svh"

module srci_back #(
    parameter int CLIP_DEPTH = srci_pkg::CLIP_DEPTH_DEF,
    localparam int IDX_W = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [srci_pkg::COUNT_W-1:0]   clip_total,
    input  srci_pkg::queue_head_t          q_head,
    output logic                           q_pop,
    output logic                           ram_we,
    output logic [IDX_W-1:0]               ram_waddr,
    output logic [srci_pkg::ENTRY_W-1:0]   ram_wdata,
    output logic                           ram_re,
    output logic [IDX_W-1:0]               ram_raddr,
    input  logic [srci_pkg::ENTRY_W-1:0]   ram_rdata,
    output logic                           piece_valid,
    input  logic                           piece_ready,
    output srci_pkg::out_item_t            piece
);

    import srci_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]       len;
        logic [15:0]       prod;
    } pend_t;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] cursor_reg, cursor_next;
    logic [PCNT_W-1:0]  n_reg, n_next;
    queue_item_t        span_reg, span_next;
    logic               pend_valid_reg, pend_valid_next;
    pend_t              pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic [COUNT_W-1:0]      limit;
    logic [COUNT_W-1:0]      next_cursor;
    clip_entry_t             clip;
    clip_entry_t             wr_entry;
    logic signed [END_W-1:0] cx1, cx2, sx1, sx2, px, pend_x, plen;
    logic                    y_gt, y_lt, left_miss, right_miss, hit;
    logic                    stop, advance, more, emit, out_free, go;
    pend_t                   new_piece;

    assign limit = (32'(clip_total) < 32'(CLIP_DEPTH)) ? clip_total : COUNT_W'(CLIP_DEPTH);
    assign next_cursor = cursor_reg + COUNT_W'(1);
    assign out_free = !out_valid_reg || piece_ready;

    always_comb
    begin
        clip       = clip_entry_t'(ram_rdata);
        cx1        = END_W'(clip.x);
        cx2        = cx1 + $signed({2'b00, clip.len});
        sx1        = END_W'(span_reg.span_x);
        sx2        = span_reg.span_end;
        y_gt       = (clip.y > span_reg.span_y);
        y_lt       = (clip.y < span_reg.span_y);
        left_miss  = (cx1 < sx1) && (cx2 < sx1);
        right_miss = (sx1 < cx1) && (sx2 < cx1);
        hit        = !y_gt && !y_lt && !left_miss && !right_miss;
        stop       = y_gt || (!y_lt && !left_miss && (right_miss || (sx2 < cx2)));
        advance    = !stop;
        more       = advance && (next_cursor < limit);
        px         = (sx1 > cx1) ? sx1 : cx1;
        pend_x     = (sx2 < cx2) ? sx2 : cx2;
        plen       = pend_x - px;
        emit       = hit && (plen != '0) && (n_reg < PCNT_W'(MAX_PIECES));
        go         = !(emit && pend_valid_reg) || out_free;

        new_piece.x    = px[15:0];
        new_piece.y    = span_reg.span_y;
        new_piece.len  = plen[15:0];
        new_piece.prod = 16'(span_reg.span_coverage) * 16'(clip.cov);

        wr_entry.x   = q_head.item.span_x;
        wr_entry.y   = q_head.item.span_y;
        wr_entry.len = q_head.item.span_len;
        wr_entry.cov = q_head.item.span_coverage;
    end

    assign ram_waddr = IDX_W'(q_head.item.entry_index);
    assign ram_wdata = wr_entry;

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        n_next          = n_reg;
        span_next       = span_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !piece_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = IDX_W'(cursor_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.item.is_load)
                    begin
                        ram_we = q_head.item.load_ok;
                    end
                    else
                    begin
                        span_next = q_head.item;
                        n_next    = '0;
                        if (cursor_reg < limit)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                        else if (q_head.item.last_of_draw)
                        begin
                            cursor_next = '0;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                if (go)
                begin
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next        = 1'b1;
                            out_next.out_x        = pend_reg.x;
                            out_next.out_y        = pend_reg.y;
                            out_next.out_len      = pend_reg.len;
                            out_next.out_coverage = div255(pend_reg.prod);
                            out_next.last_piece   = 1'b0;
                        end
                        pend_next       = new_piece;
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + PCNT_W'(1);
                    end
                    if (advance)
                    begin
                        cursor_next = next_cursor;
                    end
                    if (more)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = IDX_W'(next_cursor);
                    end
                    else
                    begin
                        if (span_reg.last_of_draw)
                        begin
                            cursor_next = '0;
                        end
                        state_next = (emit || pend_valid_reg) ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_x        = pend_reg.x;
                    out_next.out_y        = pend_reg.y;
                    out_next.out_len      = pend_reg.len;
                    out_next.out_coverage = div255(pend_reg.prod);
                    out_next.last_piece   = 1'b1;
                    pend_valid_next       = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign piece_valid = out_valid_reg;
    assign piece       = out_reg;

    `SRCI_ASSERT_IMPL(a_idle_no_pend, (state_reg == S_IDLE), !pend_valid_reg, "piece left behind")
    `SRCI_ASSERT_IMPL(a_flush_pend, (state_reg == S_FLUSH), pend_valid_reg, "flush without piece")
    `SRCI_ASSERT(a_piece_cap, (n_reg <= PCNT_W'(MAX_PIECES)), "piece count above cap")

endmodule

@@ src/span_region_clip_intersect.sv @@
// Top level of the span region clipper: clip total register, front, queue, back, clip table.
//
//   Channel     Direction  Handshake                       Payload
//   span        in         span_valid / span_ready          srci_pkg::in_item_t
//   piece       out        piece_valid / piece_ready        srci_pkg::out_item_t
//   clip_total  in         clip_total_we (no wait)          clip_total_wdata
//
// An item is registered in the queue before the back part pops it; a load is written to the
// clip table as it is popped. A subject span starts in S_IDLE, S_EVAL examines the clip entries
// in turn, and S_FLUSH gives its last piece, if any; the single clip table read port paces the walk.
// Reset clears the control state and the clip cursor; the clip table is not cleared and must
// be loaded before it is read.
// A four-item queue lets the front accept items while the back waits on the piece output.
module span_region_clip_intersect #(
    parameter int CLIP_DEPTH = srci_pkg::CLIP_DEPTH_DEF,
    localparam int IDX_W = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         span_valid,
    output logic                         span_ready,
    input  srci_pkg::in_item_t           span,
    output logic                         piece_valid,
    input  logic                         piece_ready,
    output srci_pkg::out_item_t          piece,
    input  logic                         clip_total_we,
    input  logic [srci_pkg::COUNT_W-1:0] clip_total_wdata
);

    import srci_pkg::*;

    logic [COUNT_W-1:0] clip_total_reg, clip_total_next;
    queue_head_t        q_head;
    logic               q_pop;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    assign clip_total_next = clip_total_we ? clip_total_wdata : clip_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_total_reg <= '0;
        end
        else
        begin
            clip_total_reg <= clip_total_next;
        end
    end

    srci_front #(
        .CLIP_DEPTH(CLIP_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    srci_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CLIP_DEPTH)
    ) u_clip_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srci_back #(
        .CLIP_DEPTH(CLIP_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .clip_total  (clip_total_reg),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .piece_valid (piece_valid),
        .piece_ready (piece_ready),
        .piece       (piece)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the span region clipper: clip loads, subject spans, count settings.
module testbench;
    import srci_pkg::*;

    localparam int DRAIN_CYCLES = 6000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SPANS_PER_PHASE = 20;
    localparam int IN_W = $bits(in_item_t);
    // This entry sits on the last row and ends every walk, so no walk reaches an unwritten entry.
    localparam int GUARD_IDX = 114;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                span_valid = 1'b0;
    logic                span_ready;
    in_item_t            span = '0;
    logic                piece_valid;
    logic                piece_ready = 1'b0;
    out_item_t           piece;
    logic                clip_total_we = 1'b0;
    logic [COUNT_W-1:0]  clip_total_wdata = '0;

    clip_entry_t region_tab [CLIP_DEPTH_DEF];
    int          region_count = 0;
    int          region_cursor = 0;

    in_item_t    span_feed [$];
    out_item_t   expected_pieces [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_spans = 0;
    int n_loads = 0;
    int n_pieces = 0;
    int n_errors = 0;
    int n_phases = 0;
    int n_cycles = 0;

    span_region_clip_intersect uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .span_valid       (span_valid),
        .span_ready       (span_ready),
        .span             (span),
        .piece_valid      (piece_valid),
        .piece_ready      (piece_ready),
        .piece            (piece),
        .clip_total_we    (clip_total_we),
        .clip_total_wdata (clip_total_wdata)
    );

    always #4 clk = ~clk;

    function automatic void clip_span(input in_item_t it);
        int sx1, sy, sx2, slen, cx1, cx2, cy, px, pend, plen, lim, n, prod, q;
        out_item_t pieces [MAX_PIECES];
        if (it.opcode == OP_LOAD)
        begin
            region_tab[it.entry_index].x = it.span_x;
            region_tab[it.entry_index].y = it.span_y;
            region_tab[it.entry_index].len = it.span_len;
            region_tab[it.entry_index].cov = it.span_coverage;
            n_loads++;
            return;
        end
        n_spans++;
        sx1 = $signed(it.span_x);
        sy = $signed(it.span_y);
        slen = it.span_len;
        sx2 = sx1 + slen;
        lim = (region_count < CLIP_DEPTH_DEF) ? region_count : CLIP_DEPTH_DEF;
        n = 0;
        while (region_cursor < lim)
        begin
            cy = $signed(region_tab[region_cursor].y);
            cx1 = $signed(region_tab[region_cursor].x);
            cx2 = region_tab[region_cursor].len;
            cx2 = cx1 + cx2;
            if (cy > sy)
                break;
            if (cy < sy || (cx1 < sx1 && cx2 < sx1))
            begin
                region_cursor++;
                continue;
            end
            if (sx1 < cx1 && sx2 < cx1)
                break;
            px = (sx1 > cx1) ? sx1 : cx1;
            pend = (sx2 < cx2) ? sx2 : cx2;
            plen = pend - px;
            if (plen != 0 && n < MAX_PIECES)
            begin
                prod = it.span_coverage * region_tab[region_cursor].cov;
                q = (prod + (prod >> 8) + ROUND_BIAS) >> 8;
                pieces[n].out_x = px[15:0];
                pieces[n].out_y = sy[15:0];
                pieces[n].out_len = plen[15:0];
                pieces[n].out_coverage = q[7:0];
                pieces[n].last_piece = 1'b0;
                n++;
            end
            if (sx2 < cx2)
                break;
            region_cursor++;
        end
        if (it.last_of_draw)
            region_cursor = 0;
        for (int k = 0; k < n; k++)
        begin
            pieces[k].last_piece = (k == n - 1);
            expected_pieces.push_back(pieces[k]);
        end
    endfunction

    function automatic int pick_cov();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 255;
        return $urandom_range(255);
    endfunction

    function automatic in_item_t mk_load(input int idx, input int x, input int y,
                                         input int len, input int cov);
        in_item_t it;
        it.opcode = OP_LOAD;
        it.entry_index = idx[9:0];
        it.span_x = x[15:0];
        it.span_y = y[15:0];
        it.span_len = len[15:0];
        it.span_coverage = cov[7:0];
        it.last_of_draw = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t mk_span(input int x, input int y, input int len,
                                         input int cov, input logic last);
        in_item_t it;
        it.opcode = OP_SPAN;
        it.entry_index = 10'($urandom_range(1023));
        it.span_x = x[15:0];
        it.span_y = y[15:0];
        it.span_len = len[15:0];
        it.span_coverage = cov[7:0];
        it.last_of_draw = last;
        return it;
    endfunction

    // Row-sorted clip region in entries first .. first+n-1, a few spans per row.
    task automatic add_region(input int first, input int n, input int y0, output int y_last);
        int idx, y, x, per_row, len;
        idx = first;
        y = y0;
        y_last = y0;
        while (idx < first + n)
        begin
            per_row = $urandom_range(1, 5);
            x = $urandom_range(0, 50);
            for (int k = 0; k < per_row && idx < first + n; k++)
            begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 30);
                span_feed.push_back(mk_load(idx, x, y, len, pick_cov()));
                x += len + $urandom_range(0, 20);
                idx++;
            end
            y_last = y;
            y += $urandom_range(1, 3);
        end
    endtask

    // Mostly row-sorted draws over the region, with some random spans and stray loads.
    task automatic add_spans(input int count, input int y0, input int y_last);
        int y, left, r, len;
        logic last;
        in_item_t it;
        y = y0 - 2;
        left = $urandom_range(3, 20);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            left--;
            last = (left <= 0);
            if (r < 5)
                span_feed.push_back(mk_load($urandom_range(GUARD_IDX - 1), $urandom, $urandom,
                                            $urandom, $urandom));
            else if (r < 20)
            begin
                it = IN_W'({$urandom, $urandom, $urandom});
                it.opcode = OP_SPAN;
                // A full-length span from the far corner would walk past the guard entry.
                if (it.span_x == 16'sh7fff && it.span_y == 16'sh7fff)
                    it.span_len[0] = 1'b0;
                it.last_of_draw = last | ($urandom_range(7) == 0);
                last = it.last_of_draw;
                span_feed.push_back(it);
            end
            else
            begin
                y += $urandom_range(0, 2);
                if (y > y_last + 2)
                    y = y_last + 2;
                r = $urandom_range(29);
                if (r == 0)
                    len = $urandom_range(65535);
                else if (r < 4)
                    len = 0;
                else
                    len = $urandom_range(1, 120);
                span_feed.push_back(mk_span(int'($urandom_range(300)) - 20, y, len,
                                            pick_cov(), last));
            end
            if (last)
            begin
                y = y0 - 2;
                left = $urandom_range(3, 20);
            end
        end
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        while (span_feed.size() != 0 || span_valid || expected_pieces.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        clip_total_we <= 1'b1;
        clip_total_wdata <= value;
        region_count = int'(value);
        @(posedge clk);
        clip_total_we <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s expected 0x%h, actual 0x%h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_valid <= 1'b0;
            span <= '0;
        end
        else
        begin
            if (span_valid && span_ready)
                clip_span(span);
            if (!span_valid || span_ready)
            begin
                if (span_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    span_valid <= 1'b1;
                    span <= span_feed.pop_front();
                end
                else
                    span_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            piece_ready <= 1'b0;
        else
        begin
            if (piece_valid && piece_ready)
            begin
                if (expected_pieces.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: piece expected none, actual 0x%h", $time, piece);
                end
                else
                begin
                    out_item_t want;
                    want = expected_pieces.pop_front();
                    n_pieces++;
                    compare_field("out_x", want.out_x, piece.out_x);
                    compare_field("out_y", want.out_y, piece.out_y);
                    compare_field("out_len", want.out_len, piece.out_len);
                    compare_field("out_coverage", 16'(want.out_coverage),
                                  16'(piece.out_coverage));
                    compare_field("last_piece", 16'(want.last_piece), 16'(piece.last_piece));
                end
            end
            piece_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", n_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int y_last, n, cnt, y0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With the count at its reset value of zero no span may give a piece.
        send_idle_pct = 15;
        recv_stall_pct = 15;
        span_feed.push_back(mk_span($urandom, $urandom, $urandom, 255, 1'b0));
        span_feed.push_back(mk_span($urandom, $urandom, $urandom, pick_cov(), 1'b1));
        span_feed.push_back(mk_span(0, 10, 100, 255, 1'b0));
        span_feed.push_back(mk_load(0, -32768, -32768, 65535, 255));
        span_feed.push_back(mk_load(1, 0, 10, 20, 255));
        span_feed.push_back(mk_load(2, 30, 10, 0, 77));
        span_feed.push_back(mk_load(3, 40, 10, 10, 128));
        for (int k = 0; k < 70; k++)
            span_feed.push_back(mk_load(4 + k, 3 * k, 20, 2, pick_cov()));
        add_region(74, GUARD_IDX - 74, 30, y_last);
        span_feed.push_back(mk_load(GUARD_IDX, 32767, 32767, 65535, 255));
        n_phases++;

        wait_quiet();
        write_count(COUNT_W'(CLIP_DEPTH_DEF));
        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        span_feed.push_back(mk_span(-32768, -32768, 65535, 255, 1'b0));
        span_feed.push_back(mk_span(-32768, -32768, 1, 255, 1'b0));
        span_feed.push_back(mk_span(7, 5, 10, 200, 1'b0));
        span_feed.push_back(mk_span(5, 10, 10, 0, 1'b0));
        span_feed.push_back(mk_span(15, 10, 0, 255, 1'b0));
        span_feed.push_back(mk_span(18, 10, 30, 255, 1'b0));
        span_feed.push_back(mk_span(-5, 20, 300, 200, 1'b0));
        span_feed.push_back(mk_span(0, 20, 5, 255, 1'b0));
        span_feed.push_back(mk_span(10, 10, 20, 255, 1'b0));
        span_feed.push_back(mk_span(0, y_last, 400, 255, 1'b1));
        span_feed.push_back(mk_span(-5, 20, 300, 255, 1'b1));
        span_feed.push_back(mk_span(32767, 32767, 65534, 255, 1'b0));
        span_feed.push_back(mk_span(32000, 32767, 65535, 255, 1'b1));
        span_feed.push_back(mk_span(0, 30, 65535, 128, 1'b1));
        span_feed.push_back(mk_span(-32768, 30, 65535, 1, 1'b1));
        n_phases++;

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_quiet();
            n = (ph == 3) ? 1 : ((ph % 2 == 0) ? $urandom_range(2, 16) : $urandom_range(16, 40));
            if (ph == 2)
                cnt = 0;
            else if (ph == 5)
                cnt = 2047;
            else if (ph == 6)
                cnt = n + $urandom_range(0, 50);
            else
                cnt = n;
            write_count(COUNT_W'(cnt));
            @(negedge clk);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default:
                begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            y0 = int'($urandom_range(200)) - 100;
            add_region(0, n, y0, y_last);
            add_spans(SPANS_PER_PHASE, y0, y_last);
            n_phases++;
        end

        wait_quiet();
        $display("Covered %0d subject spans and %0d clip loads in %0d phases.",
                 n_spans, n_loads, n_phases);
        $display("Checked %0d pieces, clip counts from zero to the register maximum.", n_pieces);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/srci_pkg.sv
src/srci_ram.sv
src/srci_front.sv
src/srci_back.sv
src/span_region_clip_intersect.sv
tb/testbench.sv
